>>> rtl/bkvfp_pkg.sv
package bkvfp_pkg;

	localparam int KEY_MAX_DEF   = 8;
	localparam int VALUE_MAX_DEF = 32;

	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] PRINT_LO = 8'h21;
	localparam logic [7:0] PRINT_HI = 8'h7E;

	typedef enum logic [2:0] {
		KIND_ECHO = 3'd0,
		KIND_ERR  = 3'd1,
		KIND_KEY  = 3'd2,
		KIND_VAL  = 3'd3,
		KIND_END  = 3'd4
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic  ld_rx;
		logic  out_ld;
		kind_t out_kind;
		logic  out_last;
		logic  store_key;
		logic  store_val;
		logic  clr_counts;
		logic  clr_val_count;
		logic  clr_ovf;
		logic  rd_clr;
		logic  rd_inc;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic is_open;
		logic is_colon;
		logic is_delim;
		logic is_comma;
		logic is_print;
		logic key_nz;
		logic val_nz;
		logic key_last;
		logic val_last;
	} sts_t;

endpackage

>>> rtl/bkvfp_dp.sv
module bkvfp_dp #(
	parameter int KEY_MAX   = bkvfp_pkg::KEY_MAX_DEF,
	parameter int VALUE_MAX = bkvfp_pkg::VALUE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bkvfp_pkg::cmd_t   cmd,
	output bkvfp_pkg::sts_t   sts,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        kind,
	output logic [7:0]        out_char,
	output logic              truncated,
	output logic              last
);
	import bkvfp_pkg::*;

	localparam int KC_W  = $clog2(KEY_MAX + 1);
	localparam int VC_W  = $clog2(VALUE_MAX + 1);
	localparam int KA_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int VA_W  = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
	localparam int RMAX  = (KEY_MAX > VALUE_MAX) ? KEY_MAX : VALUE_MAX;
	localparam int RI_W  = $clog2(RMAX + 1);

	logic [7:0]      rx_q;
	logic [KC_W-1:0] key_cnt_q;
	logic [VC_W-1:0] val_cnt_q;
	logic            ovf_q;
	logic [RI_W-1:0] rd_idx_q;
	logic [RI_W-1:0] rd_nxt;
	logic [RI_W-1:0] rd_addr;
	logic            key_full;
	logic            val_full;
	logic [7:0]      key_mem [KEY_MAX];
	logic [7:0]      val_mem [VALUE_MAX];
	logic [7:0]      key_rd_q;
	logic [7:0]      val_rd_q;
	logic            out_valid_q;
	kind_t           kind_q;
	logic [7:0]      char_q;
	logic            trunc_q;
	logic            last_q;
	logic [7:0]      char_d;

	always_ff @(posedge clk) begin
		if (cmd.ld_rx) begin
			rx_q <= rx_byte;
		end
	end

	assign key_full = (key_cnt_q == KC_W'(KEY_MAX));
	assign val_full = (val_cnt_q == VC_W'(VALUE_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cnt_q <= '0;
			val_cnt_q <= '0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			if (cmd.clr_counts) begin
				key_cnt_q <= '0;
			end else if (cmd.store_key && !key_full) begin
				key_cnt_q <= key_cnt_q + KC_W'(1);
			end
			if (cmd.clr_counts || cmd.clr_val_count) begin
				val_cnt_q <= '0;
			end else if (cmd.store_val && !val_full) begin
				val_cnt_q <= val_cnt_q + VC_W'(1);
			end
			if (cmd.clr_ovf) begin
				ovf_q <= 1'b0;
			end else if ((cmd.store_key && key_full) || (cmd.store_val && val_full)) begin
				ovf_q <= 1'b1;
			end
			rd_idx_q <= rd_addr;
		end
	end

	// read data registers follow the index that will be current next cycle
	assign rd_nxt  = rd_idx_q + RI_W'(1);
	assign rd_addr = cmd.rd_clr ? '0 : (cmd.rd_inc ? rd_nxt : rd_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.store_key && !key_full) begin
			key_mem[key_cnt_q[KA_W-1:0]] <= rx_q;
		end
		key_rd_q <= key_mem[rd_addr[KA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.store_val && !val_full) begin
			val_mem[val_cnt_q[VA_W-1:0]] <= rx_q;
		end
		val_rd_q <= val_mem[rd_addr[VA_W-1:0]];
	end

	always_comb begin
		unique case (cmd.out_kind)
			KIND_ERR: char_d = CH_QMARK;
			KIND_KEY: char_d = key_rd_q;
			KIND_VAL: char_d = val_rd_q;
			default:  char_d = rx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			kind_q  <= cmd.out_kind;
			char_q  <= char_d;
			trunc_q <= ovf_q && (cmd.out_kind == KIND_KEY || cmd.out_kind == KIND_VAL ||
				cmd.out_kind == KIND_END);
			last_q  <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_char  = char_q;
	assign truncated = trunc_q;
	assign last      = last_q;

	always_comb begin
		sts.out_free = !out_valid_q || !out_stall;
		sts.is_open  = (rx_q == CH_OPEN);
		sts.is_colon = (rx_q == CH_COLON);
		sts.is_comma = (rx_q == CH_COMMA);
		sts.is_delim = (rx_q == CH_COMMA) || (rx_q == CH_CLOSE);
		sts.is_print = (rx_q >= PRINT_LO) && (rx_q <= PRINT_HI);
		sts.key_nz   = (key_cnt_q != '0);
		sts.val_nz   = (val_cnt_q != '0);
		sts.key_last = (rd_nxt == RI_W'(key_cnt_q));
		sts.val_last = (rd_nxt == RI_W'(val_cnt_q));
	end

endmodule

>>> rtl/bkvfp_ctrl.sv
module bkvfp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bkvfp_pkg::sts_t sts,
	output bkvfp_pkg::cmd_t cmd
);
	import bkvfp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ECHO = 6'b000010,
		ST_ERR  = 6'b000100,
		ST_KEY  = 6'b001000,
		ST_VAL  = 6'b010000,
		ST_END  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_KEY  = 3'b010,
		PH_VAL  = 3'b100
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   err;
	logic   rdo;

	assign err = !sts.is_print || (sts.is_delim && phase_q == PH_KEY);
	assign rdo = sts.is_delim && phase_q == PH_VAL;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.out_kind = KIND_ECHO;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ld_rx = in_valid;
				if (in_valid) begin
					state_d = ST_ECHO;
				end
			end
			ST_ECHO: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = !(err || rdo);
					cmd.rd_clr   = 1'b1;
					if (err) begin
						phase_d        = PH_IDLE;
						cmd.clr_counts = 1'b1;
					end else if (sts.is_open) begin
						if (phase_q == PH_IDLE) begin
							phase_d        = PH_KEY;
							cmd.clr_counts = 1'b1;
							cmd.clr_ovf    = 1'b1;
						end
					end else if (sts.is_colon) begin
						if (phase_q == PH_KEY) begin
							phase_d           = PH_VAL;
							cmd.clr_val_count = 1'b1;
						end
					end else if (!sts.is_delim) begin
						cmd.store_key = (phase_q == PH_KEY);
						cmd.store_val = (phase_q == PH_VAL);
					end
					priority if (err) begin
						state_d = ST_ERR;
					end else if (rdo) begin
						state_d = sts.key_nz ? ST_KEY : (sts.val_nz ? ST_VAL : ST_END);
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				cmd.out_kind = KIND_ERR;
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_KEY: begin
				cmd.out_kind = KIND_KEY;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (sts.key_last) begin
						cmd.rd_clr = 1'b1;
						state_d    = sts.val_nz ? ST_VAL : ST_END;
					end else begin
						cmd.rd_inc = 1'b1;
					end
				end
			end
			ST_VAL: begin
				cmd.out_kind = KIND_VAL;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (sts.val_last) begin
						state_d = ST_END;
					end else begin
						cmd.rd_inc = 1'b1;
					end
				end
			end
			ST_END: begin
				cmd.out_kind = KIND_END;
				if (sts.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.clr_counts = 1'b1;
					cmd.clr_ovf    = 1'b1;
					phase_d        = sts.is_comma ? PH_KEY : PH_IDLE;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

>>> rtl/brace_key_value_frame_parser_core.sv
// channel | dir | handshake           | payload
// input   | in  | in_valid / in_stall  | rx_byte
// output  | out | out_valid / out_stall| kind, out_char, truncated, last
//
// A byte with a single result (echo only) goes through capture, then echo load.
// A byte that ends a record goes through capture, echo, key chars, value chars and end mark;
// key/value chars (at most KEY_MAX + VALUE_MAX) come one result per cycle from the store
// read port while the output is free; a stalled result waits in the output register.
// arst_n clears the sequencer, parse phase, counts and output valid; stores are not cleared.
module brace_key_value_frame_parser_core #(
	parameter int KEY_MAX   = bkvfp_pkg::KEY_MAX_DEF,
	parameter int VALUE_MAX = bkvfp_pkg::VALUE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] out_char,
	output logic       truncated,
	output logic       last
);
	import bkvfp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bkvfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bkvfp_dp #(
		.KEY_MAX   (KEY_MAX),
		.VALUE_MAX (VALUE_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_char  (out_char),
		.truncated (truncated),
		.last      (last)
	);

`ifndef SYNTH
	// a captured byte keeps the input closed until its last result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after a transaction");

	// error mark always closes the results of its byte
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERR) |-> (last && out_char == CH_QMARK))
		else $error("error mark not final or wrong char");

	// echo and error never carry the truncation flag
	a_no_trunc_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_ECHO || kind == KIND_ERR)) |-> !truncated)
		else $error("truncated set on echo or error");

	// key and value chars are always followed by more results
	a_rd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_KEY || kind == KIND_VAL)) |-> !last)
		else $error("record char marked last");
`endif

endmodule

>>> bench/brace_key_value_frame_parser_core_tb.sv
module brace_key_value_frame_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bkvfp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE      = 3 + KEY_MAX_DEF + VALUE_MAX_DEF + 20;
	localparam int RAND_BYTES  = 120;

	typedef enum int {PH_IDLE, PH_KEY, PH_VALUE} parse_phase_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		logic       trunc;
		logic       last;
	} result_t;

	class parse_tracker;
		parse_phase_t phase;
		logic [7:0]   key_chars[KEY_MAX_DEF];
		logic [7:0]   val_chars[VALUE_MAX_DEF];
		int           key_len;
		int           val_len;
		bit           ovf;
		result_t      expected_q[$];
		int           errors;
		int           counted;

		function new();
			phase = PH_IDLE;
			key_len = 0;
			val_len = 0;
			ovf = 0;
			errors = 0;
			counted = 0;
		endfunction

		function void add(kind_t k, logic [7:0] c, bit t);
			result_t r;
			r.kind = k;
			r.ch = c;
			r.trunc = t;
			r.last = 0;
			expected_q.push_back(r);
		endfunction

		function void to_idle();
			phase = PH_IDLE;
			key_len = 0;
			val_len = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// one accepted input transaction -> expected results
		function void take_byte(logic [7:0] c);
			add(KIND_ECHO, c, 0);
			if (c == CH_OPEN) begin
				if (phase == PH_IDLE) begin
					phase = PH_KEY;
					key_len = 0;
					val_len = 0;
					ovf = 0;
				end
			end else if (c == CH_COLON) begin
				if (phase == PH_KEY) begin
					phase = PH_VALUE;
					val_len = 0;
				end
			end else if (c == CH_COMMA || c == CH_CLOSE) begin
				if (phase == PH_VALUE) begin
					for (int i = 0; i < key_len; i++)
						add(KIND_KEY, key_chars[i], ovf);
					for (int i = 0; i < val_len; i++)
						add(KIND_VAL, val_chars[i], ovf);
					add(KIND_END, c, ovf);
					if (c == CH_COMMA) begin
						phase = PH_KEY;
						key_len = 0;
						val_len = 0;
					end else begin
						to_idle();
					end
					ovf = 0;
				end else if (phase == PH_KEY) begin
					add(KIND_ERR, CH_QMARK, 0);
					to_idle();
				end
			end else if (c >= PRINT_LO && c <= PRINT_HI) begin
				if (phase == PH_KEY) begin
					if (key_len < KEY_MAX_DEF) key_chars[key_len++] = c;
					else ovf = 1;
				end else if (phase == PH_VALUE) begin
					if (val_len < VALUE_MAX_DEF) val_chars[val_len++] = c;
					else ovf = 1;
				end
			end else begin
				add(KIND_ERR, CH_QMARK, 0);
				to_idle();
			end
			expected_q[expected_q.size() - 1].last = 1;
			counted++;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns mismatch: %s", $time, msg);
		endtask

		task check_result(logic [2:0] k, logic [7:0] c, logic t, logic l);
			result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind=%0d char=%h", k, c));
				return;
			end
			e = expected_q.pop_front();
			if (k !== e.kind)
				report($sformatf("kind %0d, want %0d (char %h)", k, e.kind, e.ch));
			if (c !== e.ch)
				report($sformatf("out_char %h, want %h (kind %0d)", c, e.ch, e.kind));
			if (t !== e.trunc)
				report($sformatf("truncated %b, want %b (kind %0d)", t, e.trunc, e.kind));
			if (l !== e.last)
				report($sformatf("last %b, want %b (kind %0d)", l, e.last, e.kind));
		endtask
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] kind;
	logic [7:0] out_char;
	logic       truncated;
	logic       last;

	bit steady = 0;
	bit hold_req = 0;

	parse_tracker tracker = new();

	brace_key_value_frame_parser_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_char  (out_char),
		.truncated (truncated),
		.last      (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(kind, out_char, truncated, last);
	end

	// receiver: random stall, or a long hold-off on request
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (steady || !arst_n) begin
				out_stall <= 0;
			end else begin
				out_stall <= ($urandom_range(99) < 29);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("brace_key_value_frame_parser_core_tb: done, errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(99) < 29) begin
				in_valid <= 0;
				@(posedge clk);
			end
		end
		in_valid <= 1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		tracker.take_byte(b);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do c = 8'($urandom_range(PRINT_HI, PRINT_LO));
		while (c == CH_OPEN || c == CH_COLON || c == CH_COMMA || c == CH_CLOSE);
		return c;
	endfunction

	// content byte, now and then replaced by any byte at all
	task automatic send_content();
		if ($urandom_range(99) < 3) send_byte(8'($urandom_range(255)));
		else send_byte(body_char());
	endtask

	task automatic send_record();
		int pairs;
		int klen;
		int vlen;
		pairs = $urandom_range(3, 1);
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
		send_byte(CH_OPEN);
		for (int p = 0; p < pairs; p++) begin
			klen = ($urandom_range(9) == 0) ? $urandom_range(11, 7) : $urandom_range(4);
			repeat (klen) send_content();
			if ($urandom_range(99) >= 5) send_byte(CH_COLON);
			vlen = ($urandom_range(9) == 0) ? $urandom_range(36, 29) : $urandom_range(6);
			repeat (vlen) send_content();
			send_byte((p == pairs - 1) ? CH_CLOSE : CH_COMMA);
		end
	endtask

	initial begin : main
		logic [7:0] directed[$];
		int rec;
		directed = '{CH_OPEN, "a", CH_COLON, "b", CH_COMMA, "c", CH_COLON, "d", CH_CLOSE,
			CH_OPEN, CH_COLON, CH_CLOSE,
			CH_OPEN, CH_OPEN, "a", CH_COLON, CH_COLON, "b", CH_CLOSE,
			CH_OPEN, "a", CH_COMMA,
			CH_CLOSE, CH_COMMA, "x",
			CH_OPEN, "k", CH_COLON, 8'h00,
			8'hFF, 8'h20, 8'h7F};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_byte(directed[i]);
		drain();

		rec = 0;
		while (tracker.counted < RAND_BYTES) begin
			if (rec == 1) hold_req = 1;
			steady = (rec >= 2 && rec < 4);
			if (rec == 4) drain();
			send_record();
			rec++;
		end
		steady = 0;

		drain();
		repeat (SETTLE) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.pending()));
		if (tracker.errors == 0) begin
			$display("brace_key_value_frame_parser_core_tb: done, clean");
		end else begin
			$display("brace_key_value_frame_parser_core_tb: done, errors");
		end
		$finish;
	end

endmodule
